/* rtl/lir_pkg.sv */
// Package for the linear interpolation resampler: widths, register indexes,
// and the command/status structs between controller and datapath.
// No dependencies.
package lir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 19;
    localparam int POS_W     = 20;
    localparam int FRAC_W    = 15;
    localparam int MAX_OUTS  = 64;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 19;

    localparam logic [POS_W-1:0]    ONE_POS    = 20'h10000;
    localparam logic [STEP_W-1:0]   STEP_RESET = 19'h10000;
    localparam logic [FRAC_W-1:0]   FRAC_ONES  = 15'h7FFF;

    localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS = 1'b1;

    typedef struct packed {
        logic load_in;
        logic pass_load;
        logic mul;
        logic emit;
        logic commit;
    } lir_cmd_t;

    typedef struct packed {
        logic pass_through;
        logic pos_int_nz;
        logic cap_hit;
        logic slot_free;
    } lir_stat_t;

endpackage

/* rtl/lir_datapath.sv */
// Datapath of the resampler: configuration, position, delay line,
// products and output register. Depends on lir_pkg.
module lir_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lir_pkg::CFG_W-1:0]         cfg_data,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] sample_in,
    input  lir_pkg::lir_cmd_t                 cmd,
    output lir_pkg::lir_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0] sample_out,
    output logic                              last_of_run
);
    import lir_pkg::*;

    logic [STEP_W-1:0]          step_reg;
    logic                       pass_reg;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] dly0_reg, dly1_reg, dly2_reg;
    logic signed [2*SAMPLE_W-1:0] prod2_reg, prod1_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       last_reg;

    logic [FRAC_W-1:0]          frac;
    logic signed [SAMPLE_W-1:0] w1, w2;
    logic [POS_W-1:0]           pos_adv;
    logic signed [2*SAMPLE_W:0] sum;
    logic                       last_next;

    assign frac    = pos_reg[FRAC_W:1];
    assign w1      = $signed({1'b0, frac});
    assign w2      = $signed({1'b0, frac ^ FRAC_ONES});
    assign pos_adv = pos_reg + {1'b0, step_reg};
    assign sum     = $signed({prod2_reg[2*SAMPLE_W-1], prod2_reg})
                   + $signed({prod1_reg[2*SAMPLE_W-1], prod1_reg});
    assign last_next = (pos_adv[POS_W-1:16] != '0) || (cnt_reg == CNT_W'(MAX_OUTS - 1));

    // Take one off the integer part once the run is over; keep the position if the cap cut the run
    always_comb
    begin
        pos_next = pos_reg;
        if (pos_reg[POS_W-1:16] != '0)
        begin
            pos_next = pos_reg - ONE_POS;
        end
        pos_next = {1'b0, pos_next[STEP_W-1:0]};
    end

    assign stat.pass_through = pass_reg;
    assign stat.pos_int_nz   = (pos_reg[POS_W-1:16] != '0);
    assign stat.cap_hit      = (cnt_reg == CNT_W'(MAX_OUTS));
    assign stat.slot_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            pass_reg      <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            dly0_reg      <= '0;
            dly1_reg      <= '0;
            dly2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP: step_reg <= cfg_data[STEP_W-1:0];
                    REG_PASS: pass_reg <= cfg_data[0];
                    default:  ;
                endcase
            end
            if (cmd.load_in)
            begin
                cnt_reg <= '0;
            end
            if (cmd.emit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                pos_reg <= pos_adv;
            end
            if (cmd.commit)
            begin
                pos_reg  <= pos_next;
                dly0_reg <= sample_reg;
                dly1_reg <= dly0_reg;
                dly2_reg <= dly1_reg;
            end
            if (cmd.emit || cmd.pass_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.mul)
        begin
            prod2_reg <= dly2_reg * w2;
            prod1_reg <= dly1_reg * w1;
        end
        if (cmd.emit)
        begin
            sample_out_reg <= sum[FRAC_W+SAMPLE_W-1:FRAC_W];
            last_reg       <= last_next;
        end
        else if (cmd.pass_load)
        begin
            sample_out_reg <= sample_reg;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign last_of_run = last_reg;

endmodule

/* rtl/lir_ctrl.sv */
// Controller of the resampler: sequences input capture, output run and
// commit. Depends on lir_pkg.
module lir_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lir_pkg::lir_stat_t stat,
    output lir_pkg::lir_cmd_t  cmd
);
    import lir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_EMIT  = 3'b100
    } lir_state_t;

    lir_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.pass_through)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.pass_load = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (stat.pos_int_nz || stat.cap_hit)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/linear_interp_resampler.sv */
// Top level of the linear interpolation resampler.
// Depends on lir_pkg, lir_ctrl and lir_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready, sample_in) takes one signed 16-bit
//   sample per transaction. Output channel (out_valid/out_ready) returns
//   zero or more interpolated samples per input; last_of_run marks the
//   final one of each run. In pass-through mode each input comes back as
//   one output, unchanged, with last_of_run set.
//   Configuration: cfg_we writes cfg_data into register cfg_index at the
//   clock edge (index 0: 3.16 step, index 1: pass-through). Write only
//   while the block is idle.
// Sequence:
//   One input at a time. An input is accepted, then its position is tested;
//   each output then takes a multiply step (the two products) and an emit
//   step (sum and load the output register), which waits while the output
//   slot is busy. A last test commits the position and the delay line. In
//   pass-through the input is loaded into the output register at the test.
//   The multiply stage and the single output register shape this sequence.
// Reset and stall:
//   Reset clears position, delay line and output valid, and loads step
//   with 1.0 and pass-through off. A stalled receiver holds the output
//   register; the run pauses until the slot frees.
module linear_interp_resampler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                last_of_run,
    input  logic                                cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lir_pkg::CFG_W-1:0]           cfg_data
);
    import lir_pkg::*;

    // Commands from controller, status back from datapath
    lir_cmd_t  cmd;
    lir_stat_t stat;

    lir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lir_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_in   (sample_in),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .last_of_run (last_of_run)
    );

endmodule

/* rtl/lir_checker.sv */
// Port-level checker for the resampler, bound to the top level.
// Depends on lir_pkg.
module lir_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [lir_pkg::SAMPLE_W-1:0] sample_out,
    input logic                                last_of_run
);
    import lir_pkg::*;

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last_of_run))
        else $error("stalled output changed");

    // One item at a time: no new input right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

    // A run still in progress keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> !in_ready)
        else $error("input opened mid-run");

    // Only the closing result of a run may wait while the input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last_of_run)
        else $error("unfinished run while idle");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .last_of_run (last_of_run)
);
